### rtl/core/s5hs_pkg.sv
// ============================================================================
// s5hs_pkg
// types, constants and codes shared by the handshake checker modules
// ============================================================================
package s5hs_pkg;

	localparam int MAX_CREDENTIAL_DEF = 8;
	localparam int MAX_MESSAGE_DEF    = 1023;

	typedef struct packed {
		logic       op;
		logic [7:0] data_byte;
		logic       last_of_message;
		logic [1:0] connect_outcome;
	} in_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] out_byte;
		logic       last_of_run;
	} out_item_t;

	typedef enum logic [1:0] {
		KIND_REPLY   = 2'd0,
		KIND_CLOSE   = 2'd1,
		KIND_CONNECT = 2'd2,
		KIND_FORWARD = 2'd3
	} kind_e;

	// command from front to back: what to emit
	typedef enum logic [2:0] {
		CMD_REPLY2  = 3'd0,
		CMD_REPLY10 = 3'd1,
		CMD_CLOSE   = 3'd2,
		CMD_CONNECT = 3'd3,
		CMD_FORWARD = 3'd4
	} cmd_e;

	typedef struct packed {
		cmd_e       cmd;
		logic [7:0] b0;
		logic [7:0] b1;
	} cmd_t;

	typedef enum logic [2:0] {
		PH_GREET  = 3'd0,
		PH_AUTH   = 3'd1,
		PH_REQ    = 3'd2,
		PH_CONN   = 3'd3,
		PH_CLOSED = 3'd4
	} phase_e;

	typedef enum logic [2:0] {
		REG_REQ_PW  = 3'd0,
		REG_USER    = 3'd1,
		REG_USER_LEN = 3'd2,
		REG_PW      = 3'd3,
		REG_PW_LEN  = 3'd4
	} reg_e;

	localparam logic [7:0] SOCKS_VER    = 8'h05;
	localparam logic [7:0] AUTH_VER     = 8'h01;
	localparam logic [7:0] REP_BAD_ATYP = 8'h08;
	localparam logic [7:0] REP_BAD_CMD  = 8'h07;
	localparam logic [7:0] REP_NO_START = 8'h03;
	localparam logic [7:0] REP_FAILED   = 8'h04;
	localparam logic [7:0] NO_METHOD    = 8'hff;
	localparam logic [7:0] METH_PW      = 8'h02;
	localparam logic [7:0] ATYP_V4      = 8'h01;
	localparam logic [7:0] ATYP_DOMAIN  = 8'h03;
	localparam logic [7:0] ATYP_V6      = 8'h04;
	localparam logic [7:0] REQ_CONNECT  = 8'h01;
	localparam logic [7:0] REQ_UDP      = 8'h03;

endpackage

### rtl/core/socks5_handshake_checker.sv
// ============================================================================
// socks5_handshake_checker
// server side socks5 handshake: greeting, credential check, request, forward
// ============================================================================
// usage
//   in channel   : one client byte or one connect outcome per item
//   out channel  : reply bytes, close, begin-connect or forwarded bytes;
//                  last_of_run marks the final result of one input item
//   cfg channel  : register writes, always ready; idle-only is the user's duty
// latency: the front classifies an item in the cycle it is accepted and
//   pushes at most one command into a four-deep queue; the first result is visible
//   the next cycle when the queue was empty
// throughput: one item per cycle while the queue has room; a command emits
//   one result per cycle while out_ready is high, so a ten-byte reply holds
//   the back end while the front keeps taking items until the queue fills
// reset: asynchronous, clears registers to zero, phase to greeting and
//   empties the queue
// stall: when out_ready is low the queue fills and in ready drops
// ============================================================================
module socks5_handshake_checker import s5hs_pkg::*; #(
	parameter int MAX_CREDENTIAL = MAX_CREDENTIAL_DEF,
	parameter int MAX_MESSAGE    = MAX_MESSAGE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	// front to queue
	logic f_valid, f_ready;
	cmd_t f_cmd;
	// queue to back
	logic b_valid, b_ready;
	cmd_t b_cmd;

	assign cfg_ready = 1'b1;

	s5hs_front #(
		.MAX_CREDENTIAL(MAX_CREDENTIAL),
		.MAX_MESSAGE(MAX_MESSAGE)
	) u_front (
		.clk, .arst_n,
		.in_valid, .in_ready, .in_item(in_data),
		.cfg_valid, .cfg_index, .cfg_data,
		.cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
	);

	s5hs_queue u_queue (
		.clk, .arst_n,
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cmd),
		.rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_cmd)
	);

	s5hs_back u_back (
		.clk, .arst_n,
		.cmd_valid(b_valid), .cmd_ready(b_ready), .cmd(b_cmd),
		.out_valid, .out_ready, .out_item(out_data)
	);

`ifndef SYNTHESIS
	// a command is only dropped from the queue on the closing result
	a_pop_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		b_ready |-> (out_valid && out_ready && out_data.last_of_run))
		else $error("command retired without last result");
	// close and begin-connect are always single results
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (out_data.kind == KIND_CLOSE || out_data.kind == KIND_CONNECT))
		|-> out_data.last_of_run)
		else $error("multi-result close or connect");
	// input is refused only while the queue is full
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> b_valid)
		else $error("input stalled with empty queue");
`endif
endmodule

### rtl/core/s5hs_front.sv
// ============================================================================
// s5hs_front
// accepts client items, tracks the session and classifies each message
// ============================================================================
module s5hs_front import s5hs_pkg::*; #(
	parameter int MAX_CREDENTIAL = MAX_CREDENTIAL_DEF,
	parameter int MAX_MESSAGE    = MAX_MESSAGE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_item,
	input  logic        cfg_valid,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	output logic        cmd_valid,
	input  logic        cmd_ready,
	output cmd_t        cmd
);
	localparam int CW = $clog2(MAX_CREDENTIAL + 1);
	localparam int BW = $clog2(MAX_MESSAGE + 1);
	localparam int IW = (MAX_CREDENTIAL > 1) ? $clog2(MAX_CREDENTIAL) : 1;

	logic        req_pw_q;
	logic [63:0] user_q, pw_q;
	logic [3:0]  user_len_q, pw_len_q;
	logic [CW-1:0] ulen, plen;

	phase_e      phase_q;
	logic [BW-1:0] cnt_q;
	logic [7:0]  dlen_q, slen_q, cmd_q, atyp_q;
	logic        meth_q, ver_q, um_q, pm_q, await_q, long_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_pw_q   <= 1'b0;
			user_q     <= '0;
			user_len_q <= '0;
			pw_q       <= '0;
			pw_len_q   <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_REQ_PW:   req_pw_q   <= cfg_data[0];
				REG_USER:     user_q     <= cfg_data;
				REG_USER_LEN: user_len_q <= cfg_data[3:0];
				REG_PW:       pw_q       <= cfg_data;
				REG_PW_LEN:   pw_len_q   <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	assign ulen = (32'(user_len_q) > MAX_CREDENTIAL) ? CW'(MAX_CREDENTIAL) : CW'(user_len_q);
	assign plen = (32'(pw_len_q) > MAX_CREDENTIAL) ? CW'(MAX_CREDENTIAL) : CW'(pw_len_q);

	// next state
	phase_e      phase_d;
	logic [BW-1:0] cnt_d;
	logic [7:0]  dlen_d, slen_d, cmd_d, atyp_d;
	logic        meth_d, ver_d, um_d, pm_d, await_d, long_d;
	logic        emit;
	cmd_t        c;
	logic [7:0]  b;
	logic [BW-1:0] pos;
	logic [10:0] len, dl2, idx_u, idx_p;
	logic        fin_ok, take;

	assign in_ready = cmd_ready;
	assign b   = in_item.data_byte;
	assign pos = cnt_q;

	always_comb begin
		phase_d = phase_q; cnt_d = cnt_q; dlen_d = dlen_q; slen_d = slen_q;
		cmd_d = cmd_q; atyp_d = atyp_q; meth_d = meth_q; ver_d = ver_q;
		um_d = um_q; pm_d = pm_q; await_d = await_q; long_d = long_q;
		emit = 1'b0;
		c = '{cmd: CMD_CLOSE, b0: 8'h00, b1: 8'h00};
		len = '0; dl2 = 11'(dlen_q) + 11'd2;
		idx_u = 11'(pos) - 11'd2;
		idx_p = 11'(pos) - 11'd3 - 11'(dlen_q);
		fin_ok = 1'b0; take = 1'b0;
		if (phase_q <= PH_CONN) begin
			if (in_item.op) begin
				if (await_q) begin
					await_d = 1'b0;
					emit = 1'b1;
					c.cmd = CMD_REPLY10;
					case (in_item.connect_outcome)
						2'd0: begin
							c.b1 = 8'h00;
							phase_d = PH_CONN;
						end
						2'd1: c.b1 = REP_NO_START;
						default: c.b1 = REP_FAILED;
					endcase
				end
			end else if (phase_q == PH_CONN) begin
				emit = 1'b1;
				c.cmd = CMD_FORWARD;
				c.b0 = b;
			end else if (!await_q) begin
				if (32'(pos) >= MAX_MESSAGE) long_d = 1'b1;
				else begin
					take = 1'b1;
					cnt_d = pos + 1'b1;
				end
				if (take) begin
					case (phase_q)
						PH_GREET: begin
							if (pos == 0) begin
								ver_d = (b == SOCKS_VER);
								meth_d = 1'b0;
							end else if (pos == 1) dlen_d = b;
							else if (b == (req_pw_q ? METH_PW : 8'h00)) meth_d = 1'b1;
						end
						PH_AUTH: begin
							if (pos == 0) ver_d = (b == AUTH_VER);
							else if (pos == 1) begin
								dlen_d = b; um_d = 1'b1; pm_d = 1'b1;
							end else if (11'(pos) < dl2) begin
								if (idx_u >= 11'(ulen) ||
								    user_q[8*idx_u[IW-1:0] +: 8] != b)
									um_d = 1'b0;
							end else if (11'(pos) == dl2) slen_d = b;
							else if (idx_p >= 11'(plen) ||
							         pw_q[8*idx_p[IW-1:0] +: 8] != b)
								pm_d = 1'b0;
						end
						default: begin
							if (pos == 0) ver_d = (b == SOCKS_VER);
							else if (pos == 1) cmd_d = b;
							else if (pos == 3) atyp_d = b;
							else if (pos == 4) dlen_d = b;
						end
					endcase
				end
				if (in_item.last_of_message) begin
					len = 11'(cnt_d);
					cnt_d = '0;
					long_d = 1'b0;
					emit = 1'b1;
					if (long_q || (32'(pos) >= MAX_MESSAGE)) begin
						c.cmd = CMD_CLOSE; phase_d = PH_CLOSED;
					end else begin
						case (phase_q)
							PH_GREET: begin
								if (len <= 11'd2 || !ver_d || 11'(dlen_d) != len - 11'd2) begin
									c.cmd = CMD_CLOSE; phase_d = PH_CLOSED;
								end else if (!meth_d) begin
									c = '{cmd: CMD_REPLY2, b0: SOCKS_VER, b1: NO_METHOD};
								end else begin
									c = '{cmd: CMD_REPLY2, b0: SOCKS_VER,
									      b1: req_pw_q ? METH_PW : 8'h00};
									phase_d = req_pw_q ? PH_AUTH : PH_REQ;
								end
							end
							PH_AUTH: begin
								if (len <= 11'd2 || !ver_d || len <= 11'(dlen_d) + 11'd2 ||
								    11'(slen_d) != len - 11'(dlen_d) - 11'd3) begin
									c.cmd = CMD_CLOSE; phase_d = PH_CLOSED;
								end else if (um_d && pm_d && 11'(dlen_d) == 11'(ulen) &&
								             11'(slen_d) == 11'(plen)) begin
									c = '{cmd: CMD_REPLY2, b0: AUTH_VER, b1: 8'h00};
									phase_d = PH_REQ;
								end else
									c = '{cmd: CMD_REPLY2, b0: AUTH_VER, b1: 8'h01};
							end
							default: begin
								if (len <= 11'd4 || !ver_d) fin_ok = 1'b0;
								else if (atyp_d == ATYP_V4) fin_ok = (len == 11'd10);
								else if (atyp_d == ATYP_DOMAIN)
									fin_ok = (len == 11'(dlen_d) + 11'd7);
								else if (atyp_d == ATYP_V6) fin_ok = (len == 11'd22);
								else fin_ok = 1'b1;
								if (!fin_ok) begin
									c.cmd = CMD_CLOSE; phase_d = PH_CLOSED;
								end else if (atyp_d != ATYP_V4 && atyp_d != ATYP_DOMAIN &&
								             atyp_d != ATYP_V6) begin
									c = '{cmd: CMD_REPLY10, b0: 8'h00, b1: REP_BAD_ATYP};
								end else if (cmd_d == REQ_CONNECT) begin
									c.cmd = CMD_CONNECT; await_d = 1'b1;
								end else if (cmd_d == REQ_UDP) begin
									c = '{cmd: CMD_REPLY10, b0: 8'h00, b1: 8'h00};
									phase_d = PH_CONN;
								end else
									c = '{cmd: CMD_REPLY10, b0: 8'h00, b1: REP_BAD_CMD};
							end
						endcase
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_GREET; cnt_q <= '0; dlen_q <= '0; slen_q <= '0;
			cmd_q <= '0; atyp_q <= '0; meth_q <= 1'b0; ver_q <= 1'b0;
			um_q <= 1'b0; pm_q <= 1'b0; await_q <= 1'b0; long_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			phase_q <= phase_d; cnt_q <= cnt_d; dlen_q <= dlen_d; slen_q <= slen_d;
			cmd_q <= cmd_d; atyp_q <= atyp_d; meth_q <= meth_d; ver_q <= ver_d;
			um_q <= um_d; pm_q <= pm_d; await_q <= await_d; long_q <= long_d;
		end
	end

	assign cmd_valid = in_valid && emit;
	assign cmd = c;
endmodule

### rtl/core/s5hs_queue.sv
// ============================================================================
// s5hs_queue
// short command queue between classifier and reply generator
// ============================================================================
module s5hs_queue import s5hs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  cmd_t wr_data,
	output logic rd_valid,
	input  logic rd_ready,
	output cmd_t rd_data
);
	cmd_t       mem_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic       wr, rd;

	assign wr_ready = (cnt_q != 3'd4);
	assign rd_valid = (cnt_q != 3'd0);
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 1'b1;
			if (rd) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + 3'(wr) - 3'(rd);
		end
	end
endmodule

### rtl/core/s5hs_back.sv
// ============================================================================
// s5hs_back
// expands each command into result items, one per cycle while not stalled
// ============================================================================
module s5hs_back import s5hs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_ready,
	input  cmd_t      cmd,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);
	logic [3:0] idx_q;
	logic [3:0] n_res;
	logic       fire, done;
	out_item_t  o;

	always_comb begin
		o = '{kind: KIND_REPLY, out_byte: 8'h00, last_of_run: 1'b0};
		n_res = 4'd1;
		case (cmd.cmd)
			CMD_REPLY2: begin
				n_res = 4'd2;
				o.out_byte = (idx_q == 4'd0) ? cmd.b0 : cmd.b1;
			end
			CMD_REPLY10: begin
				n_res = 4'd10;
				case (idx_q)
					4'd0: o.out_byte = SOCKS_VER;
					4'd1: o.out_byte = cmd.b1;
					4'd3: o.out_byte = 8'h01;
					default: o.out_byte = 8'h00;
				endcase
			end
			CMD_CLOSE:   o.kind = KIND_CLOSE;
			CMD_CONNECT: o.kind = KIND_CONNECT;
			CMD_FORWARD: begin
				o.kind = KIND_FORWARD;
				o.out_byte = cmd.b0;
			end
			default: ;
		endcase
		done = (idx_q == n_res - 4'd1);
		o.last_of_run = done;
	end

	assign out_valid = cmd_valid;
	assign out_item  = o;
	assign fire      = out_valid && out_ready;
	assign cmd_ready = fire && done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) idx_q <= '0;
		else if (fire) idx_q <= done ? 4'd0 : idx_q + 4'd1;
	end
endmodule
